[rtl/delayed_message_timer_table_assert.svh]
// Assertion macros for the delayed message timer table.
`ifndef DELAYED_MESSAGE_TIMER_TABLE_ASSERT_SVH
`define DELAYED_MESSAGE_TIMER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define DMT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmt assertion failed");
`define DMT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmt assertion failed");
`else
`define DMT_ASSERT_IMP(label, ante, cons)
`define DMT_ASSERT_NXT(label, ante, cons)
`endif
`endif

[rtl/dmt_pkg.sv]
// Shared types and constants of the delayed message timer table.
`default_nettype none
package dmt_pkg;

    localparam int MSG_W           = 32;
    localparam int CD_W            = 15;
    localparam int ID_W            = 8;
    localparam int EXACT_W         = 24;
    localparam int ACT_W           = 2;
    localparam int STAT_W          = 2;
    localparam int OCNT_W          = 5;
    localparam int MAX_POSTS       = 16;
    localparam int POST_AW         = $clog2(MAX_POSTS);
    localparam int POST_CW         = $clog2(MAX_POSTS + 1);
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int ENT_W           = MSG_W + CD_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_SET       = 2'd0,
        ACT_REMOVE    = 2'd1,
        ACT_REMOVE_ID = 2'd2,
        ACT_TICK      = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_EXAM,
        S_MOVE_RD,
        S_MOVE_WR,
        S_LOAD,
        S_POST_RD,
        S_POST_LD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [MSG_W-1:0] msg;
        logic [CD_W-1:0]  cd;
    } entry_t;

    typedef struct packed {
        logic            hit_exact;
        logic            hit_id;
        logic            cd_zero;
        logic [CD_W-1:0] cd_dec;
    } alu_res_t;

endpackage
`default_nettype wire

[rtl/dmt_channels.sv]
// Request and response channel interfaces of the delayed message timer table.
`default_nettype none
interface dmt_req_if;
    import dmt_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [MSG_W-1:0] message;
    logic [CD_W-1:0]  delay;
    logic             sink_ready;

    modport source (output valid, action, message, delay, sink_ready, input ready);
    modport sink (input valid, action, message, delay, sink_ready, output ready);
endinterface

interface dmt_rsp_if;
    import dmt_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              posted_valid;
    logic [MSG_W-1:0]  posted_message;
    logic              last;
    logic [OCNT_W-1:0] entries_used;
    logic [OCNT_W-1:0] high_water;

    modport source (output valid, status, posted_valid, posted_message, last,
                    entries_used, high_water, input ready);
    modport sink (input valid, status, posted_valid, posted_message, last,
                  entries_used, high_water, output ready);
endinterface
`default_nettype wire

[rtl/dmt_ram.sv]
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module dmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/dmt_alu.sv]
// Shared compare and decrement unit applied to one table entry per step.
`default_nettype none
module dmt_alu (
    input  dmt_pkg::entry_t         entry,
    input  logic [dmt_pkg::MSG_W-1:0] key,
    output dmt_pkg::alu_res_t       res
);
    import dmt_pkg::*;

    always_comb
    begin
        res.hit_exact = (entry.msg[EXACT_W-1:0] == key[EXACT_W-1:0]);
        res.hit_id    = (entry.msg[ID_W-1:0] == key[ID_W-1:0]);
        res.cd_zero   = (entry.cd == '0);
        res.cd_dec    = entry.cd - CD_W'(1);
    end

endmodule
`default_nettype wire

[rtl/delayed_message_timer_table.sv]
// Top level of the delayed message timer table: sequencer, entry store, post buffer.
// A set goes through dispatch and result load. A remove or tick goes through dispatch, scan and
// examine per examined entry, move read and move write per deleted entry, a closing scan (not
// after an exact delete) and result load, or post read and load for the first post of a tick
// that posts. Further posts are read and loaded after each result transfer; a new request
// waits for idle after the last result. Reset clears counts and sequencer, not the entries.
`default_nettype none
`include "delayed_message_timer_table_assert.svh"
module delayed_message_timer_table #(
    parameter int TABLE_DEPTH = dmt_pkg::DEF_TABLE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    dmt_req_if.sink   req,
    dmt_rsp_if.source rsp
);
    import dmt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t              state_reg, state_next;
    action_t             act_reg, act_next;
    logic [MSG_W-1:0]    msg_reg, msg_next;
    logic [CD_W-1:0]     delay_reg, delay_next;
    logic                sready_reg, sready_next;
    status_t             stat_reg, stat_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    peak_reg, peak_next;
    logic [POST_CW-1:0]  npost_reg, npost_next;
    logic [POST_CW-1:0]  kpost_reg, kpost_next;
    status_t             out_status_reg, out_status_next;
    logic                out_pvalid_reg, out_pvalid_next;
    logic [MSG_W-1:0]    out_msg_reg, out_msg_next;
    logic                out_last_reg, out_last_next;

    logic                ent_we;
    logic [IDX_W-1:0]    ent_waddr;
    logic [ENT_W-1:0]    ent_wdata;
    logic [IDX_W-1:0]    ent_raddr;
    logic [ENT_W-1:0]    ent_rdata;
    entry_t              ent_rd;

    logic                pst_we;
    logic [POST_AW-1:0]  pst_waddr;
    logic [MSG_W-1:0]    pst_wdata;
    logic [POST_AW-1:0]  pst_raddr;
    logic [MSG_W-1:0]    pst_rdata;

    alu_res_t            alu_res;
    logic                drop_hit;
    logic [CNT_W-1:0]    count_inc;
    logic [CNT_W-1:0]    last_cnt;
    logic [POST_CW-1:0]  npost_dec;
    logic [CNT_W+OCNT_W-1:0] count_ext;
    logic [CNT_W+OCNT_W-1:0] peak_ext;

    assign ent_rd    = entry_t'(ent_rdata);
    assign count_inc = count_reg + CNT_W'(1);
    assign last_cnt  = count_reg - CNT_W'(1);
    assign npost_dec = npost_reg - POST_CW'(1);

    dmt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    dmt_ram #(
        .WIDTH (MSG_W),
        .DEPTH (MAX_POSTS)
    ) u_post_ram (
        .clk   (clk),
        .we    (pst_we),
        .waddr (pst_waddr),
        .wdata (pst_wdata),
        .raddr (pst_raddr),
        .rdata (pst_rdata)
    );

    dmt_alu u_alu (
        .entry (ent_rd),
        .key   (msg_reg),
        .res   (alu_res)
    );

    // An entry leaves the table on a match for the removes, or on a post during a tick.
    always_comb
    begin
        case (act_reg)
            ACT_REMOVE:    drop_hit = alu_res.hit_exact;
            ACT_REMOVE_ID: drop_hit = alu_res.hit_id;
            ACT_TICK:      drop_hit = alu_res.cd_zero && sready_reg
                                      && (npost_reg < POST_CW'(MAX_POSTS));
            default:       drop_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (act_reg == ACT_SET)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = S_EXAM;
                end
                else if (act_reg == ACT_TICK && npost_reg != '0)
                begin
                    state_next = S_POST_RD;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_EXAM:
            begin
                if (drop_hit)
                begin
                    state_next = S_MOVE_RD;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_MOVE_RD:
            begin
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                if (act_reg == ACT_REMOVE)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_LOAD:
            begin
                state_next = S_OUT;
            end
            S_POST_RD:
            begin
                state_next = S_POST_LD;
            end
            S_POST_LD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    if (out_pvalid_reg && !out_last_reg)
                    begin
                        state_next = S_POST_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        act_next        = act_reg;
        msg_next        = msg_reg;
        delay_next      = delay_reg;
        sready_next     = sready_reg;
        stat_next       = stat_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        peak_next       = peak_reg;
        npost_next      = npost_reg;
        kpost_next      = kpost_reg;
        out_status_next = out_status_reg;
        out_pvalid_next = out_pvalid_reg;
        out_msg_next    = out_msg_reg;
        out_last_next   = out_last_reg;
        ent_we          = 1'b0;
        ent_waddr       = idx_reg[IDX_W-1:0];
        ent_wdata       = {msg_reg, delay_reg};
        ent_raddr       = idx_reg[IDX_W-1:0];
        pst_we          = 1'b0;
        pst_waddr       = npost_reg[POST_AW-1:0];
        pst_wdata       = ent_rd.msg;
        pst_raddr       = kpost_reg[POST_AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next    = action_t'(req.action);
                    msg_next    = req.message;
                    delay_next  = req.delay;
                    sready_next = req.sink_ready;
                end
            end
            S_DISPATCH:
            begin
                idx_next   = '0;
                npost_next = '0;
                kpost_next = '0;
                case (act_reg)
                    ACT_SET:
                    begin
                        if (msg_reg[ID_W-1:0] == '0)
                        begin
                            stat_next = ST_MISS;
                        end
                        else if (count_reg >= CNT_W'(TABLE_DEPTH))
                        begin
                            stat_next = ST_FULL;
                        end
                        else
                        begin
                            stat_next  = ST_OK;
                            ent_we     = 1'b1;
                            ent_waddr  = count_reg[IDX_W-1:0];
                            count_next = count_inc;
                            if (count_inc > peak_reg)
                            begin
                                peak_next = count_inc;
                            end
                        end
                    end
                    ACT_TICK:
                    begin
                        stat_next = ST_OK;
                    end
                    default:
                    begin
                        stat_next = ST_MISS;
                    end
                endcase
            end
            S_EXAM:
            begin
                if (drop_hit)
                begin
                    stat_next = ST_OK;
                    if (act_reg == ACT_TICK)
                    begin
                        pst_we     = 1'b1;
                        npost_next = npost_reg + POST_CW'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    if (act_reg == ACT_TICK && !alu_res.cd_zero)
                    begin
                        ent_we    = 1'b1;
                        ent_wdata = {ent_rd.msg, alu_res.cd_dec};
                    end
                end
            end
            S_MOVE_RD:
            begin
                // Fetch the last entry; it fills the freed slot next cycle.
                ent_raddr  = last_cnt[IDX_W-1:0];
                count_next = last_cnt;
            end
            S_MOVE_WR:
            begin
                ent_we    = 1'b1;
                ent_wdata = ent_rdata;
                // A tick skips the moved-in entry; remove by id examines it.
                if (act_reg == ACT_TICK)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_LOAD:
            begin
                out_status_next = stat_reg;
                out_pvalid_next = 1'b0;
                out_msg_next    = '0;
                out_last_next   = 1'b1;
            end
            S_POST_LD:
            begin
                out_status_next = ST_OK;
                out_pvalid_next = 1'b1;
                out_msg_next    = pst_rdata;
                out_last_next   = (kpost_reg == npost_dec);
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    kpost_next = kpost_reg + POST_CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stat_reg  <= ST_OK;
            idx_reg   <= '0;
            count_reg <= '0;
            peak_reg  <= '0;
            npost_reg <= '0;
            kpost_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            peak_reg  <= peak_next;
            npost_reg <= npost_next;
            kpost_reg <= kpost_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        msg_reg        <= msg_next;
        delay_reg      <= delay_next;
        sready_reg     <= sready_next;
        out_status_reg <= out_status_next;
        out_pvalid_reg <= out_pvalid_next;
        out_msg_reg    <= out_msg_next;
        out_last_reg   <= out_last_next;
    end

    assign count_ext = {{OCNT_W{1'b0}}, count_reg};
    assign peak_ext  = {{OCNT_W{1'b0}}, peak_reg};

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = (state_reg == S_OUT);
    assign rsp.status         = out_status_reg;
    assign rsp.posted_valid   = out_pvalid_reg;
    assign rsp.posted_message = out_msg_reg;
    assign rsp.last           = out_last_reg;
    assign rsp.entries_used   = count_ext[OCNT_W-1:0];
    assign rsp.high_water     = peak_ext[OCNT_W-1:0];

    `DMT_ASSERT_IMP(a_peak_covers_count, 1'b1, peak_reg >= count_reg)
    `DMT_ASSERT_IMP(a_post_limit, 1'b1, npost_reg <= POST_CW'(MAX_POSTS))
    `DMT_ASSERT_IMP(a_post_in_buffer, rsp.valid && rsp.posted_valid, kpost_reg < npost_reg)
    `DMT_ASSERT_NXT(a_drop_one, state_reg == S_MOVE_RD, count_reg == $past(count_reg) - CNT_W'(1))

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the delayed message timer table.
`default_nettype none
module tb_top;
    import dmt_pkg::*;

    localparam int DEPTH        = DEF_TABLE_DEPTH;
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE_CYCLES = 160;
    localparam int MAX_REPORTS  = 10;
    localparam int HI_W         = MSG_W - EXACT_W;

    typedef struct {
        status_t          status;
        logic             posted_valid;
        logic [MSG_W-1:0] posted_message;
        logic             last;
        logic [4:0]       entries_used;
        logic [4:0]       high_water;
    } timer_result_t;

    logic clk;
    logic rst_n;

    dmt_req_if req_ch ();
    dmt_rsp_if rsp_ch ();

    delayed_message_timer_table #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the table, updated when a request transfer completes.
    logic [MSG_W-1:0] tbl_msg [DEPTH];
    logic [CD_W-1:0]  tbl_cd [DEPTH];
    int               tbl_count;
    int               tbl_peak;

    timer_result_t pending_results [$];

    int fail_count;
    int sender_idle_pct;
    int rsp_stall_pct;
    int idle_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_failure(input string what);
        if (fail_count < MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic void drop_entry(input int slot);
        tbl_count--;
        tbl_msg[slot] = tbl_msg[tbl_count];
        tbl_cd[slot]  = tbl_cd[tbl_count];
    endfunction

    function automatic void push_result(input status_t st, input logic pv,
                                        input logic [MSG_W-1:0] pm, input logic lst);
        timer_result_t r;
        r.status         = st;
        r.posted_valid   = pv;
        r.posted_message = pm;
        r.last           = lst;
        r.entries_used   = tbl_count[4:0];
        r.high_water     = tbl_peak[4:0];
        pending_results.push_back(r);
    endfunction

    function automatic void predict_timer_step(input action_t act, input logic [MSG_W-1:0] msg,
                                               input logic [CD_W-1:0] dly, input logic snk);
        status_t          st;
        logic             hit;
        logic [MSG_W-1:0] posts [$];
        st = ST_OK;
        case (act)
            ACT_SET:
            begin
                if (msg[ID_W-1:0] == '0)
                    st = ST_MISS;
                else if (tbl_count >= DEPTH)
                    st = ST_FULL;
                else
                begin
                    tbl_msg[tbl_count] = msg;
                    tbl_cd[tbl_count]  = dly;
                    tbl_count++;
                    if (tbl_count > tbl_peak)
                        tbl_peak = tbl_count;
                end
            end
            ACT_REMOVE:
            begin
                st  = ST_MISS;
                hit = 1'b0;
                for (int i = 0; i < tbl_count && !hit; i++)
                begin
                    if (tbl_msg[i][EXACT_W-1:0] == msg[EXACT_W-1:0])
                    begin
                        drop_entry(i);
                        hit = 1'b1;
                        st  = ST_OK;
                    end
                end
            end
            ACT_REMOVE_ID:
            begin
                st = ST_MISS;
                do
                begin
                    hit = 1'b0;
                    for (int i = 0; i < tbl_count && !hit; i++)
                    begin
                        if (tbl_msg[i][ID_W-1:0] == msg[ID_W-1:0])
                        begin
                            drop_entry(i);
                            hit = 1'b1;
                            st  = ST_OK;
                        end
                    end
                end
                while (hit);
            end
            default:
            begin
                // The entry moved into a freed slot is skipped until the next tick.
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (tbl_cd[i] == '0)
                    begin
                        if (snk && posts.size() < MAX_POSTS)
                        begin
                            posts.push_back(tbl_msg[i]);
                            drop_entry(i);
                        end
                    end
                    else
                        tbl_cd[i] = tbl_cd[i] - 1'b1;
                end
                if (posts.size() == 0)
                    push_result(ST_OK, 1'b0, '0, 1'b1);
                for (int k = 0; k < posts.size(); k++)
                    push_result(ST_OK, 1'b1, posts[k], k == posts.size() - 1);
                return;
            end
        endcase
        push_result(st, 1'b0, '0, 1'b1);
    endfunction

    task automatic send_request(input action_t act, input logic [MSG_W-1:0] msg,
                                input logic [CD_W-1:0] dly, input logic snk);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.message    <= msg;
        req_ch.delay      <= dly;
        req_ch.sink_ready <= snk;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predict_timer_step(act, msg, dly, snk);
    endtask

    // The sender goes idle first so the last transfer is not taken a second time.
    task automatic wait_for_drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [MSG_W-1:0] pick_message();
        logic [MSG_W-1:0] m;
        int               r;
        m = $urandom;
        r = $urandom_range(99);
        if (r < 70)
            m[ID_W-1:0] = ID_W'($urandom_range(1, 6));
        else if (r < 75)
            m[ID_W-1:0] = '0;
        return m;
    endfunction

    function automatic logic [CD_W-1:0] pick_delay();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return CD_W'($urandom_range(3));
        else if (r < 95)
            return CD_W'($urandom_range(20));
        return CD_W'($urandom_range(32767));
    endfunction

    task automatic test_empty_table();
        send_request(ACT_SET, 32'hFFFF_FF00, 15'h7FFF, 1'b1);
        send_request(ACT_REMOVE, 32'h0000_0000, 15'h0000, 1'b0);
        send_request(ACT_REMOVE_ID, 32'h0000_0012, 15'h0000, 1'b0);
        send_request(ACT_TICK, 32'h0000_0000, 15'h0000, 1'b1);
    endtask

    task automatic test_fill_and_reject();
        logic [MSG_W-1:0] m;
        logic [CD_W-1:0]  d;
        for (int i = 0; i < DEPTH; i++)
        begin
            m = {8'(i * 17), 16'hA5C3 ^ 16'(i), 8'(i + 1)};
            d = 15'(i % 3);
            if (i % 4 == 0)
                m[ID_W-1:0] = 8'h5A;
            if (i == 3)
                d = 15'h7FFF;
            if (i == DEPTH - 1)
            begin
                m = 32'hFFFF_FFFF;
                d = 15'h0000;
            end
            send_request(ACT_SET, m, d, 1'b0);
        end
        send_request(ACT_SET, 32'h1234_5601, 15'h0001, 1'b1);
        // A null id is reported even when the table is full.
        send_request(ACT_SET, 32'h0000_0000, 15'h0001, 1'b1);
    endtask

    task automatic test_remove();
        // Only the low 24 bits take part in an exact match.
        send_request(ACT_REMOVE, tbl_msg[1] ^ 32'hFF00_0000, 15'h0000, 1'b0);
        send_request(ACT_REMOVE, 32'hFF00_0000, 15'h7FFF, 1'b1);
        send_request(ACT_REMOVE_ID, 32'h0000_005A, 15'h0000, 1'b0);
    endtask

    task automatic test_tick_expiry();
        send_request(ACT_TICK, 32'h0000_0000, 15'h0000, 1'b0);
        send_request(ACT_TICK, 32'h0000_0000, 15'h0000, 1'b1);
        send_request(ACT_TICK, 32'hFFFF_FFFF, 15'h7FFF, 1'b1);
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct,
                                       input int stall_pct, input bit drain_pauses);
        int               sent;
        int               r;
        int               idx;
        int               burst;
        logic [MSG_W-1:0] m;
        sender_idle_pct = idle_pct;
        rsp_stall_pct   = stall_pct;
        sent = 0;
        while (sent < items)
        begin
            r = $urandom_range(99);
            if (r < 50)
            begin
                burst = $urandom_range(1, 6);
                for (int i = 0; i < burst; i++)
                    send_request(ACT_SET, pick_message(), pick_delay(),
                                 1'($urandom_range(1)));
                burst = $urandom_range(1, 4);
                for (int i = 0; i < burst; i++)
                    send_request(ACT_TICK, $urandom, CD_W'($urandom),
                                 $urandom_range(99) < 80);
                sent += burst;
                burst = 0;
                sent += 0;
            end
            else if (r < 65)
            begin
                m = pick_message();
                if (tbl_count > 0 && $urandom_range(99) < 80)
                begin
                    idx = $urandom_range(tbl_count - 1);
                    m   = tbl_msg[idx];
                    if ($urandom_range(1))
                        m[MSG_W-1:EXACT_W] = HI_W'($urandom);
                end
                send_request(ACT_REMOVE, m, CD_W'($urandom), 1'($urandom_range(1)));
                sent++;
            end
            else if (r < 75)
            begin
                m = pick_message();
                if (tbl_count > 0 && $urandom_range(99) < 80)
                begin
                    idx = $urandom_range(tbl_count - 1);
                    m   = $urandom;
                    m[ID_W-1:0] = tbl_msg[idx][ID_W-1:0];
                end
                send_request(ACT_REMOVE_ID, m, CD_W'($urandom), 1'($urandom_range(1)));
                sent++;
            end
            else if (r < 80)
            begin
                // Fill every free slot with an expired entry, then tick with the sink ready.
                while (tbl_count < DEPTH)
                begin
                    m = $urandom;
                    m[ID_W-1:0] = ID_W'($urandom_range(1, 255));
                    send_request(ACT_SET, m, '0, 1'($urandom_range(1)));
                    sent++;
                end
                send_request(ACT_TICK, $urandom, CD_W'($urandom), 1'b1);
                sent++;
            end
            else if (r < 90)
            begin
                send_request(action_t'($urandom_range(3)), $urandom, CD_W'($urandom),
                             1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                burst = $urandom_range(2, 8);
                for (int i = 0; i < burst; i++)
                    send_request(ACT_TICK, $urandom, CD_W'($urandom),
                                 $urandom_range(99) < 70);
                sent += burst;
            end
            if (r < 50)
                sent += 3;
            if (drain_pauses && $urandom_range(99) < 10)
                wait_for_drain();
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        timer_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_failure("result transfer with no result pending");
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status
                    || rsp_ch.posted_valid !== want.posted_valid
                    || rsp_ch.posted_message !== want.posted_message
                    || rsp_ch.last !== want.last
                    || rsp_ch.entries_used !== want.entries_used
                    || rsp_ch.high_water !== want.high_water)
                    report_failure($sformatf(
                        {"want st=%0d pv=%0d msg=%h last=%0d used=%0d hw=%0d, ",
                         "got st=%0d pv=%0d msg=%h last=%0d used=%0d hw=%0d"},
                        want.status, want.posted_valid, want.posted_message, want.last,
                        want.entries_used, want.high_water, rsp_ch.status,
                        rsp_ch.posted_valid, rsp_ch.posted_message, rsp_ch.last,
                        rsp_ch.entries_used, rsp_ch.high_water));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("** delayed_message_timer_table: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_SET;
        req_ch.message    = '0;
        req_ch.delay      = '0;
        req_ch.sink_ready = 1'b0;
        rsp_ch.ready      = 1'b0;
        tbl_count         = 0;
        tbl_peak          = 0;
        fail_count        = 0;
        idle_cycles       = 0;
        sender_idle_pct   = 0;
        rsp_stall_pct     = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_fill_and_reject();
        test_remove();
        test_tick_expiry();
        test_random_traffic(95, 0, 0, 1'b0);
        test_random_traffic(95, 55, 0, 1'b1);
        test_random_traffic(95, 0, 55, 1'b0);
        test_random_traffic(95, 19, 19, 1'b1);

        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_failure("results still pending at end of run");
        if (fail_count == 0)
            $display("** delayed_message_timer_table: PASSED **");
        else
            $display("** delayed_message_timer_table: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/dmt_pkg.sv
rtl/dmt_channels.sv
rtl/dmt_ram.sv
rtl/dmt_alu.sv
rtl/delayed_message_timer_table.sv
tb/tb_top.sv
